// ----- design/assert_macros.svh -----
// Assertion macros for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- design/dsch_pkg.sv -----
// Shared types and constants of the disk request scheduler.
package dsch_pkg;
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int TRACK_BITS_DEF = 12;
  localparam int ID_BITS_DEF = 16;

  localparam int POLICY_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_OUT_W = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_POLICY = 1'b0;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  localparam logic [POLICY_W-1:0] POL_FIFO = 3'd0;
  localparam logic [POLICY_W-1:0] POL_SSTF = 3'd1;
  localparam logic [POLICY_W-1:0] POL_LOOK = 3'd2;
  localparam logic [POLICY_W-1:0] POL_CLOOK = 3'd3;
  localparam logic [POLICY_W-1:0] POL_FLOOK = 3'd4;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_DONE
  } seq_state_t;
endpackage

// ----- design/disk_request_scheduler_unit.sv -----
// Top level of the disk request scheduler: config port, front queue and back end.
//
//  channel | handshake         | payload
//  in      | in_valid/in_stall | opcode request_id request_track head_track direction_in
//  out     | out_valid/out_stall | status grant_id grant_track direction_out pending_count
//  cfg     | psel/penable/pwrite | paddr pwdata prdata
//
// An insert passes from queue head through the idle, prep and done states to the
// result; a scanning select also visits every entry held in the scan state, through the
// single distance compare. Fifo selects and empty-table selects skip the scan.
// Synchronous reset empties the table and queue and sets policy to fifo.
// The front queue holds two transactions and accepts while the back end works;
// a stalled result holds the back end in its final state.
module disk_request_scheduler_unit import dsch_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TRACK_BITS = TRACK_BITS_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   opcode,
  input  logic [ID_BITS-1:0]     request_id,
  input  logic [TRACK_BITS-1:0]  request_track,
  input  logic [TRACK_BITS-1:0]  head_track,
  input  logic                   direction_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [ID_BITS-1:0]     grant_id,
  output logic [TRACK_BITS-1:0]  grant_track,
  output logic                   direction_out,
  output logic [COUNT_OUT_W-1:0] pending_count,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);
  localparam int ITEM_W = 2 + ID_BITS + 2 * TRACK_BITS;

  logic [POLICY_W-1:0] policy;
  logic q_valid;
  logic q_pop;
  logic [ITEM_W-1:0] q_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POLICY) ? PDATA_W'(policy) : '0;

  always_ff @(posedge clk) begin
    if (rst) policy <= POL_FIFO;
    else if (psel && penable && pwrite && paddr[2] == REG_POLICY)
      policy <= pwdata[POLICY_W-1:0];
  end

  dsch_front #(
    .TRACK_BITS(TRACK_BITS),
    .ID_BITS(ID_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .request_id(request_id),
    .request_track(request_track),
    .head_track(head_track),
    .direction_in(direction_in),
    .q_valid(q_valid),
    .q_data(q_data),
    .q_pop(q_pop)
  );

  dsch_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TRACK_BITS(TRACK_BITS),
    .ID_BITS(ID_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .policy(policy),
    .q_valid(q_valid),
    .q_data(q_data),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .grant_id(grant_id),
    .grant_track(grant_track),
    .direction_out(direction_out),
    .pending_count(pending_count)
  );
endmodule

// ----- design/dsch_front.sv -----
// Front end: accepts transactions into a two-entry queue.
module dsch_front import dsch_pkg::*; #(
  parameter int TRACK_BITS = TRACK_BITS_DEF,
  parameter int ID_BITS = ID_BITS_DEF,
  localparam int ITEM_W = 2 + ID_BITS + 2 * TRACK_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic [ID_BITS-1:0]    request_id,
  input  logic [TRACK_BITS-1:0] request_track,
  input  logic [TRACK_BITS-1:0] head_track,
  input  logic              direction_in,
  output logic              q_valid,
  output logic [ITEM_W-1:0] q_data,
  input  logic              q_pop
);
  logic [ITEM_W-1:0] slot [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic push;
  logic is_sel;

  // classify: insert fields are only kept for inserts, head fields only for selects
  always_comb begin
    is_sel = (opcode == OP_SELECT);
  end

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != 2'd0);
  assign q_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= {is_sel,
                       is_sel ? '0 : request_id,
                       is_sel ? '0 : request_track,
                       is_sel ? head_track : '0,
                       direction_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      if (push && !q_pop) fill <= fill + 2'd1;
      else if (!push && q_pop) fill <= fill - 2'd1;
    end
  end
endmodule

// ----- design/dsch_back.sv -----
// Back end: request table, scan sequencer and result register.
module dsch_back import dsch_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TRACK_BITS = TRACK_BITS_DEF,
  parameter int ID_BITS = ID_BITS_DEF,
  localparam int ITEM_W = 2 + ID_BITS + 2 * TRACK_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [POLICY_W-1:0]   policy,
  input  logic                  q_valid,
  input  logic [ITEM_W-1:0]     q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [ID_BITS-1:0]    grant_id,
  output logic [TRACK_BITS-1:0] grant_track,
  output logic                  direction_out,
  output logic [COUNT_OUT_W-1:0] pending_count
);
`include "assert_macros.svh"
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W = TRACK_BITS + 1;

  logic [TRACK_BITS-1:0] entry_track [QUEUE_DEPTH];
  logic [ID_BITS-1:0]    entry_ident [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] entry_active;
  logic [CNT_W-1:0] count;

  seq_state_t state, state_next;

  logic item_sel;
  logic [ID_BITS-1:0] item_id;
  logic [TRACK_BITS-1:0] item_trk;
  logic [TRACK_BITS-1:0] item_head;
  logic item_dir;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] best_idx;
  logic [KEY_W-1:0] best_key;
  logic [TRACK_BITS-1:0] best_trk;
  logic [ID_BITS-1:0] best_id;
  logic best_found;

  logic do_prep, do_scan, do_done, out_take, out_free;
  logic scan_pol, scan_last, freeze_swap;
  logic full, empty, ins_ok, grant_ok;

  logic [TRACK_BITS-1:0] cur_trk;
  logic [ID_BITS-1:0] cur_id;
  logic cur_act;
  logic [TRACK_BITS-1:0] cur_dist;
  logic cur_side, cur_cand, cur_better;
  logic [KEY_W-1:0] cur_key;

  logic [IDX_W-1:0] g_idx;
  logic [TRACK_BITS-1:0] g_trk;
  logic [ID_BITS-1:0] g_id;

  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || out_take;
  assign scan_pol = policy inside {POL_SSTF, POL_LOOK, POL_CLOOK, POL_FLOOK};
  assign full = (count >= CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) >= count;
  assign freeze_swap = (policy == POL_FLOOK) && !(|entry_active);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid) state_next = S_PREP;
      S_PREP: begin
        if (item_sel && !empty && scan_pol) state_next = S_SCAN;
        else state_next = S_DONE;
      end
      S_SCAN: if (scan_last) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    do_prep = 1'b0;
    do_scan = 1'b0;
    do_done = 1'b0;
    case (state)
      S_IDLE: q_pop = q_valid;
      S_PREP: do_prep = 1'b1;
      S_SCAN: do_scan = 1'b1;
      S_DONE: do_done = out_free;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {item_sel, item_id, item_trk, item_head, item_dir} <= q_data;
    end
  end

  // per-entry candidate key, smaller wins, strict compare keeps the oldest
  always_comb begin
    cur_trk = entry_track[scan_idx];
    cur_id = entry_ident[scan_idx];
    cur_act = entry_active[scan_idx];
    cur_dist = (cur_trk >= item_head) ? cur_trk - item_head : item_head - cur_trk;
    cur_side = item_dir ? (cur_trk >= item_head) : (cur_trk <= item_head);
    cur_cand = (policy == POL_FLOOK) ? cur_act : 1'b1;
    case (policy)
      POL_SSTF: cur_key = {1'b0, cur_dist};
      POL_CLOOK: cur_key = {cur_trk < item_head, cur_trk};
      default: cur_key = {!cur_side, cur_dist};
    endcase
    cur_better = cur_cand && (!best_found || cur_key < best_key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      scan_idx <= '0;
    end else if (do_prep) begin
      best_found <= 1'b0;
      scan_idx <= '0;
    end else if (do_scan) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (cur_better) best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_scan && cur_better) begin
      best_idx <= scan_idx;
      best_key <= cur_key;
      best_trk <= cur_trk;
      best_id <= cur_id;
    end
  end

  assign ins_ok = do_done && !item_sel && !full;
  assign grant_ok = do_done && item_sel && !empty;
  assign g_idx = best_found ? best_idx : '0;
  assign g_trk = best_found ? best_trk : entry_track[0];
  assign g_id = best_found ? best_id : entry_ident[0];

  always_ff @(posedge clk) begin
    if (ins_ok) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (CNT_W'(i) == count) begin
          entry_track[i] <= item_trk;
          entry_ident[i] <= item_id;
        end
      end
    end else if (grant_ok) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (IDX_W'(i) >= g_idx) begin
          entry_track[i] <= entry_track[i+1];
          entry_ident[i] <= entry_ident[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_active <= '0;
    end else if (do_prep && item_sel && freeze_swap) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        entry_active[i] <= (CNT_W'(i) < count);
      end
    end else if (grant_ok) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (IDX_W'(i) >= g_idx) begin
          entry_active[i] <= (CNT_W'(i + 1) < count) ? entry_active[i+1] : 1'b0;
        end
      end
      entry_active[QUEUE_DEPTH-1] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (ins_ok) count <= count + CNT_W'(1);
    else if (grant_ok) count <= count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (do_done) out_valid <= 1'b1;
    else if (out_take) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (do_done) begin
      if (!item_sel) begin
        status <= full ? ST_FULL : ST_INSERTED;
        grant_id <= '0;
        grant_track <= '0;
        direction_out <= item_dir;
        pending_count <= COUNT_OUT_W'(full ? count : count + CNT_W'(1));
      end else if (empty) begin
        status <= ST_EMPTY;
        grant_id <= '0;
        grant_track <= '0;
        direction_out <= item_dir;
        pending_count <= COUNT_OUT_W'(count);
      end else begin
        status <= ST_GRANTED;
        grant_id <= g_id;
        grant_track <= g_trk;
        direction_out <= (policy == POL_CLOOK) ? (g_trk >= item_head) : item_dir;
        pending_count <= COUNT_OUT_W'(count - CNT_W'(1));
      end
    end
  end

  `ASSERT_CLK(a_scan_in_range, (state == S_SCAN) |-> (CNT_W'(scan_idx) < count),
              "scan index past table fill")
  `ASSERT_CLK(a_scan_exit, (state == S_SCAN) |=> (state == S_SCAN || state == S_DONE),
              "scan left to wrong state")
  `ASSERT_CLK(a_insert_count, ins_ok |=> (count == $past(count) + CNT_W'(1)),
              "insert did not grow table")
  `ASSERT_NEVER(a_no_overfill, count > CNT_W'(QUEUE_DEPTH), "table overfilled")
endmodule
